// ===== hdl/cv2d_pkg.sv =====
// cv2d_pkg: shared constants, codes, word types and helper functions for the
// 5x5 border-padded convolution. No dependencies.
package cv2d_pkg;

  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned KERNEL_SIZE    = 5;
  localparam int unsigned COEF_FRAC_BITS = 7;
  localparam int unsigned ROW_SLOTS      = 6;
  localparam int unsigned TAPS           = 5;
  localparam int unsigned HALF           = KERNEL_SIZE / 2;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned COEF_W         = 12;
  localparam int unsigned COL_W          = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W          = COL_W + 1;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned CRD_W          = 15;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = TAPS * COEF_W;
  localparam int unsigned PROD_W         = PIX_W + COEF_W + 1;
  localparam int unsigned RSUM_W         = PROD_W + 3;
  localparam int unsigned SUM_W          = RSUM_W + 3;
  localparam int unsigned PIX_MAX        = 255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ROW0,
    CFG_COEF_ROW1,
    CFG_COEF_ROW2,
    CFG_COEF_ROW3,
    CFG_COEF_ROW4,
    CFG_BORDER_MODE,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BORDER_ZERO      = 2'd0,
    BORDER_REPLICATE = 2'd1,
    BORDER_MIRROR    = 2'd2
  } border_e;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_row;
    logic             end_of_frame;
  } out_word_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] sel;
  } tap_map_t;

  typedef struct packed {
    logic                      shift;
    logic                      emit;
    tap_map_t [TAPS-1:0]       vmap;
    tap_map_t [TAPS-1:0]       hmap;
    logic                      eor;
    logic                      eof;
  } rd_ctrl_t;

  typedef struct packed {
    logic                emit;
    tap_map_t [TAPS-1:0] hmap;
    logic                eor;
    logic                eof;
  } win_ctrl_t;

  typedef struct packed {
    logic ok;
    logic signed [CRD_W-1:0] q;
  } coord_t;

  typedef logic [TAPS-1:0][CFG_DATA_W-1:0] coef_rows_t;
  typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] window_t;

  function automatic coord_t map_coord(logic signed [CRD_W-1:0] p,
                                       logic signed [CRD_W-1:0] n,
                                       border_e mode);
    coord_t r;
    logic signed [CRD_W-1:0] q;
    r.ok = 1'b1;
    q    = p;
    if (p < 0 || p >= n) begin
      unique case (mode)
        BORDER_ZERO:      r.ok = 1'b0;
        BORDER_REPLICATE: q = (p < 0) ? CRD_W'(0) : n - CRD_W'(1);
        default:          q = (p < 0) ? -p - CRD_W'(1) : (n <<< 1) - CRD_W'(1) - p;
      endcase
      if (q < 0) q = CRD_W'(0);
      if (q > n - CRD_W'(1)) q = n - CRD_W'(1);
    end
    r.q = q;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(ROW_SLOTS - 1)) ? SLOT_W'(0) : s + SLOT_W'(1);
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_at(coef_rows_t rows, int s, int t);
    if (s - 2 > int'(HALF) || 2 - s > int'(HALF) || t - 2 > int'(HALF) ||
        2 - t > int'(HALF)) begin
      return '0;
    end
    return $signed(rows[s][t*COEF_W +: COEF_W]);
  endfunction

endpackage

// ===== hdl/cv2d_line_mem.sv =====
// cv2d_line_mem: line store, one column of all six row slots per entry.
// Byte-lane write, registered read with same-cycle write forwarding. Uses cv2d_pkg.
module cv2d_line_mem (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [cv2d_pkg::COL_W-1:0]                    waddr_i,
  input  logic [cv2d_pkg::SLOT_W-1:0]                   wslot_i,
  input  logic [cv2d_pkg::PIX_W-1:0]                    wdata_i,
  input  logic                                          re_i,
  input  logic [cv2d_pkg::COL_W-1:0]                    raddr_i,
  output logic [cv2d_pkg::ROW_SLOTS*cv2d_pkg::PIX_W-1:0] rdata_o
);

  logic [cv2d_pkg::ROW_SLOTS*cv2d_pkg::PIX_W-1:0] mem_q [cv2d_pkg::MAX_WIDTH];
  logic [cv2d_pkg::ROW_SLOTS*cv2d_pkg::PIX_W-1:0] rdata_q;
  logic                                           fwd_q;
  logic [cv2d_pkg::SLOT_W-1:0]                    fwd_slot_q;
  logic [cv2d_pkg::PIX_W-1:0]                     fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wslot_i*cv2d_pkg::PIX_W +: cv2d_pkg::PIX_W] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      fwd_q      <= we_i && (waddr_i == raddr_i);
      fwd_slot_q <= wslot_i;
      fwd_data_q <= wdata_i;
    end
  end

  // merge the byte written in the read cycle
  always_comb begin
    rdata_o = rdata_q;
    if (fwd_q) begin
      rdata_o[fwd_slot_q*cv2d_pkg::PIX_W +: cv2d_pkg::PIX_W] = fwd_data_q;
    end
  end

endmodule

// ===== hdl/cv2d_ctrl.sv =====
// cv2d_ctrl: configuration registers, input/output position counters,
// line store addressing and border mapping of rows and columns. Uses cv2d_pkg.
module cv2d_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                in_fire_i,
  input  cv2d_pkg::in_word_t                  in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output cv2d_pkg::coef_rows_t                coef_o,
  output logic                                we_o,
  output logic [cv2d_pkg::COL_W-1:0]          waddr_o,
  output logic [cv2d_pkg::SLOT_W-1:0]         wslot_o,
  output logic [cv2d_pkg::PIX_W-1:0]          wdata_o,
  output logic [cv2d_pkg::COL_W-1:0]          raddr_o,
  output cv2d_pkg::rd_ctrl_t                  s1_o
);

  localparam int unsigned CW = cv2d_pkg::CRD_W;

  cv2d_pkg::coef_rows_t            coef_q;
  cv2d_pkg::border_e               border_q;
  logic [cv2d_pkg::WID_W-1:0]      width_q;
  logic [cv2d_pkg::ROW_W-1:0]      height_q;

  logic [cv2d_pkg::COL_W-1:0]  in_col_q, in_col_d;
  logic [cv2d_pkg::ROW_W-1:0]  in_row_q, in_row_d;
  logic [cv2d_pkg::SLOT_W-1:0] in_slot_q, in_slot_d;
  logic [cv2d_pkg::COL_W-1:0]  out_col_q, out_col_d;
  logic [cv2d_pkg::ROW_W-1:0]  out_row_q, out_row_d;
  logic [cv2d_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  cv2d_pkg::rd_ctrl_t          s1_q, s1_d;

  logic [cv2d_pkg::WID_W-1:0]  eff_w;
  logic [cv2d_pkg::ROW_W-1:0]  eff_h;
  logic [cv2d_pkg::COL_W-1:0]  col_cl;
  logic [cv2d_pkg::WID_W-1:0]  col_nx;
  logic [cv2d_pkg::WID_W-1:0]  c2;
  logic [cv2d_pkg::WID_W-1:0]  c2_wrap;
  logic [cv2d_pkg::ROW_W:0]    tag;
  logic [cv2d_pkg::SLOT_W-1:0] tslot;
  logic                        step, emit, pre, last_out;
  logic signed [CW-1:0]        c_ext, tag_ext, w_ext, h_ext;
  logic signed [CW-1:0]        hp [cv2d_pkg::TAPS];
  logic signed [CW-1:0]        hd [cv2d_pkg::TAPS];
  logic signed [CW-1:0]        vp [cv2d_pkg::TAPS];
  logic signed [CW-1:0]        vd [cv2d_pkg::TAPS];
  logic signed [CW-1:0]        vs [cv2d_pkg::TAPS];
  cv2d_pkg::coord_t            hm [cv2d_pkg::TAPS];
  cv2d_pkg::coord_t            vm [cv2d_pkg::TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q    <= '0;
      coef_q[2] <= cv2d_pkg::CFG_DATA_W'(64'h8000_0000);
      border_q  <= cv2d_pkg::BORDER_MIRROR;
      width_q   <= cv2d_pkg::WID_W'(256);
      height_q  <= cv2d_pkg::ROW_W'(256);
    end else if (cfg_valid_i) begin
      unique case (cv2d_pkg::cfg_idx_e'(cfg_index_i))
        cv2d_pkg::CFG_COEF_ROW0: coef_q[0] <= cfg_data_i;
        cv2d_pkg::CFG_COEF_ROW1: coef_q[1] <= cfg_data_i;
        cv2d_pkg::CFG_COEF_ROW2: coef_q[2] <= cfg_data_i;
        cv2d_pkg::CFG_COEF_ROW3: coef_q[3] <= cfg_data_i;
        cv2d_pkg::CFG_COEF_ROW4: coef_q[4] <= cfg_data_i;
        cv2d_pkg::CFG_BORDER_MODE: begin
          border_q <= (cfg_data_i[1:0] == 2'd3) ? cv2d_pkg::BORDER_MIRROR
                                               : cv2d_pkg::border_e'(cfg_data_i[1:0]);
        end
        cv2d_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[cv2d_pkg::WID_W-1:0];
        cv2d_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[cv2d_pkg::ROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    eff_w = width_q;
    if (width_q < cv2d_pkg::WID_W'(3)) begin
      eff_w = cv2d_pkg::WID_W'(3);
    end else if (width_q > cv2d_pkg::WID_W'(cv2d_pkg::MAX_WIDTH)) begin
      eff_w = cv2d_pkg::WID_W'(cv2d_pkg::MAX_WIDTH);
    end
    eff_h = (height_q < cv2d_pkg::ROW_W'(3)) ? cv2d_pkg::ROW_W'(3) : height_q;
  end

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    step       = 1'b0;
    emit       = 1'b0;
    pre        = 1'b0;
    we_o       = 1'b0;
    last_out   = 1'b0;

    col_cl = ({1'b0, in_col_q} >= eff_w) ? cv2d_pkg::COL_W'(eff_w - cv2d_pkg::WID_W'(1))
                                         : in_col_q;
    col_nx = {1'b0, col_cl} + cv2d_pkg::WID_W'(1);

    if (in_fire_i) begin
      if (in_row_q < eff_h) begin
        if (in_data_i.opcode == cv2d_pkg::OP_PIXEL) begin
          step = 1'b1;
          we_o = 1'b1;
          if (col_nx >= eff_w) begin
            in_col_d  = '0;
            in_row_d  = in_row_q + cv2d_pkg::ROW_W'(1);
            in_slot_d = cv2d_pkg::next_slot(in_slot_q);
          end else begin
            in_col_d = col_nx[cv2d_pkg::COL_W-1:0];
          end
          emit = (in_row_q > cv2d_pkg::ROW_W'(2)) ||
                 ((in_row_q == cv2d_pkg::ROW_W'(2)) && (col_cl >= cv2d_pkg::COL_W'(2)));
          pre  = (in_row_q == cv2d_pkg::ROW_W'(2)) && (col_cl < cv2d_pkg::COL_W'(2));
        end
      end else begin
        step = 1'b1;
        emit = 1'b1;
      end
    end

    if (step && (out_row_q >= eff_h)) begin
      emit       = 1'b0;
      pre        = 1'b0;
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
    end

    if (emit) begin
      last_out = ({1'b0, out_col_q} == eff_w - cv2d_pkg::WID_W'(1)) &&
                 (out_row_q == eff_h - cv2d_pkg::ROW_W'(1));
      if ({1'b0, out_col_q} == eff_w - cv2d_pkg::WID_W'(1)) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + cv2d_pkg::ROW_W'(1);
        out_slot_d = cv2d_pkg::next_slot(out_slot_q);
      end else begin
        out_col_d = out_col_q + cv2d_pkg::COL_W'(1);
      end
      if (last_out) begin
        in_col_d   = '0;
        in_row_d   = '0;
        in_slot_d  = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_slot_d = '0;
      end
    end

    // fetch input column when priming, else two ahead, wrapping into next row
    c2      = {1'b0, out_col_q} + cv2d_pkg::WID_W'(2);
    c2_wrap = c2 - eff_w;
    if (pre) begin
      raddr_o = col_cl;
      tag     = '0;
      tslot   = '0;
    end else if (c2 < eff_w) begin
      raddr_o = c2[cv2d_pkg::COL_W-1:0];
      tag     = {1'b0, out_row_q};
      tslot   = out_slot_q;
    end else begin
      raddr_o = c2_wrap[cv2d_pkg::COL_W-1:0];
      tag     = {1'b0, out_row_q} + (cv2d_pkg::ROW_W+1)'(1);
      tslot   = cv2d_pkg::next_slot(out_slot_q);
    end

    c_ext   = $signed(CW'(out_col_q));
    tag_ext = $signed(CW'(tag));
    w_ext   = $signed(CW'(eff_w));
    h_ext   = $signed(CW'(eff_h));

    s1_d       = '0;
    s1_d.shift = emit | pre;
    s1_d.emit  = emit;
    s1_d.eor   = ({1'b0, out_col_q} == eff_w - cv2d_pkg::WID_W'(1));
    s1_d.eof   = last_out;
    for (int t = 0; t < int'(cv2d_pkg::TAPS); t++) begin
      hp[t] = c_ext + CW'(t) - CW'(2);
      hm[t] = cv2d_pkg::map_coord(hp[t], w_ext, border_q);
      hd[t] = hm[t].q - c_ext + CW'(2);
      s1_d.hmap[t].ok  = hm[t].ok;
      s1_d.hmap[t].sel = hd[t][cv2d_pkg::SLOT_W-1:0];

      vp[t] = tag_ext + CW'(t) - CW'(2);
      vm[t] = cv2d_pkg::map_coord(vp[t], h_ext, border_q);
      vd[t] = vm[t].q - tag_ext;
      vs[t] = $signed(CW'(tslot)) + vd[t];
      if (vs[t] < 0) begin
        vs[t] = vs[t] + CW'(cv2d_pkg::ROW_SLOTS);
      end else if (vs[t] >= CW'(cv2d_pkg::ROW_SLOTS)) begin
        vs[t] = vs[t] - CW'(cv2d_pkg::ROW_SLOTS);
      end
      s1_d.vmap[t].ok  = vm[t].ok;
      s1_d.vmap[t].sel = vs[t][cv2d_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      s1_q       <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      if (adv_i) begin
        s1_q <= s1_d;
      end
    end
  end

  assign coef_o  = coef_q;
  assign waddr_o = col_cl;
  assign wslot_o = in_slot_q;
  assign wdata_o = in_data_i.pixel_in;
  assign s1_o    = s1_q;

endmodule

// ===== hdl/cv2d_window.sv =====
// cv2d_window: picks the five mapped rows out of each fetched column and
// shifts the column into the 5x5 window. Uses cv2d_pkg.
module cv2d_window (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           adv_i,
  input  cv2d_pkg::rd_ctrl_t                             s1_i,
  input  logic [cv2d_pkg::ROW_SLOTS*cv2d_pkg::PIX_W-1:0] rdata_i,
  output cv2d_pkg::window_t                              win_o,
  output cv2d_pkg::win_ctrl_t                            s2_o
);

  cv2d_pkg::window_t                                    win_q;
  cv2d_pkg::win_ctrl_t                                  s2_q;
  logic [cv2d_pkg::TAPS-1:0][cv2d_pkg::PIX_W-1:0]       col_vec;
  logic [cv2d_pkg::ROW_SLOTS-1:0][cv2d_pkg::PIX_W-1:0] lanes;

  assign lanes = rdata_i;

  always_comb begin
    for (int s = 0; s < int'(cv2d_pkg::TAPS); s++) begin
      if (s1_i.vmap[s].ok && (s1_i.vmap[s].sel < cv2d_pkg::SLOT_W'(cv2d_pkg::ROW_SLOTS))) begin
        col_vec[s] = lanes[s1_i.vmap[s].sel];
      end else begin
        col_vec[s] = '0;
      end
    end
  end

  // oldest column at index 0
  always_ff @(posedge clk_i) begin
    if (adv_i && s1_i.shift) begin
      for (int i = 0; i < int'(cv2d_pkg::TAPS) - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[cv2d_pkg::TAPS-1] <= col_vec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv_i) begin
      s2_q.emit <= s1_i.emit;
      s2_q.hmap <= s1_i.hmap;
      s2_q.eor  <= s1_i.eor;
      s2_q.eof  <= s1_i.eof;
    end
  end

  assign win_o = win_q;
  assign s2_o  = s2_q;

endmodule

// ===== hdl/cv2d_mac.sv =====
// cv2d_mac: horizontal tap selection, 25 products, registered adder tree,
// floor and clamp, output word register. Uses cv2d_pkg.
module cv2d_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  cv2d_pkg::coef_rows_t  coef_i,
  input  cv2d_pkg::window_t     win_i,
  input  cv2d_pkg::win_ctrl_t   s2_i,
  output logic                  out_valid_o,
  output cv2d_pkg::out_word_t   out_data_o
);

  logic signed [cv2d_pkg::PROD_W-1:0] prod_q [cv2d_pkg::TAPS][cv2d_pkg::TAPS];
  logic signed [cv2d_pkg::RSUM_W-1:0] rsum_q [cv2d_pkg::TAPS];
  logic signed [cv2d_pkg::SUM_W-1:0]  sum_q;
  logic [2:0]                         emit_q, eor_q, eof_q;
  logic                               out_valid_q;
  cv2d_pkg::out_word_t                out_data_q;

  logic [cv2d_pkg::PIX_W-1:0]         tap  [cv2d_pkg::TAPS][cv2d_pkg::TAPS];
  logic signed [cv2d_pkg::RSUM_W-1:0] racc [cv2d_pkg::TAPS];
  logic signed [cv2d_pkg::SUM_W-1:0]  acc;
  logic signed [cv2d_pkg::SUM_W-1:0]  shifted;
  logic [cv2d_pkg::PIX_W-1:0]         pix;

  always_comb begin
    for (int s = 0; s < int'(cv2d_pkg::TAPS); s++) begin
      for (int t = 0; t < int'(cv2d_pkg::TAPS); t++) begin
        if (s2_i.hmap[t].ok && (s2_i.hmap[t].sel < cv2d_pkg::SLOT_W'(cv2d_pkg::TAPS))) begin
          tap[s][t] = win_i[s2_i.hmap[t].sel][s];
        end else begin
          tap[s][t] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < int'(cv2d_pkg::TAPS); s++) begin
      racc[s] = '0;
      for (int t = 0; t < int'(cv2d_pkg::TAPS); t++) begin
        racc[s] = racc[s] + cv2d_pkg::RSUM_W'(prod_q[s][t]);
      end
    end
    acc = '0;
    for (int s = 0; s < int'(cv2d_pkg::TAPS); s++) begin
      acc = acc + cv2d_pkg::SUM_W'(rsum_q[s]);
    end
  end

  always_comb begin
    shifted = sum_q >>> cv2d_pkg::COEF_FRAC_BITS;
    if (sum_q < 0) begin
      pix = '0;
    end else if (shifted > cv2d_pkg::SUM_W'(cv2d_pkg::PIX_MAX)) begin
      pix = cv2d_pkg::PIX_W'(cv2d_pkg::PIX_MAX);
    end else begin
      pix = shifted[cv2d_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < int'(cv2d_pkg::TAPS); s++) begin
        for (int t = 0; t < int'(cv2d_pkg::TAPS); t++) begin
          prod_q[s][t] <= cv2d_pkg::PROD_W'($signed({1'b0, tap[s][t]}) *
                                            cv2d_pkg::coef_at(coef_i, s, t));
        end
        rsum_q[s] <= racc[s];
      end
      sum_q                   <= acc;
      out_data_q.pixel_out    <= pix;
      out_data_q.end_of_row   <= eor_q[2];
      out_data_q.end_of_frame <= eof_q[2];
      eor_q                   <= {eor_q[1:0], s2_i.eor};
      eof_q                   <= {eof_q[1:0], s2_i.eof};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      emit_q      <= {emit_q[1:0], s2_i.emit};
      out_valid_q <= emit_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/conv2d_5x5_border_padding.sv =====
// conv2d_5x5_border_padding: top level of the streaming 5x5 convolution.
// Uses cv2d_pkg, cv2d_ctrl, cv2d_line_mem, cv2d_window and cv2d_mac.
//
// The block takes one word per clock and sustains one result per clock while not
// stalled; the rate is set by the line store, one 1024 x 48-bit memory with one
// write and one read port, which delivers one column of all six buffered rows per
// cycle. A result passes the ctrl, window and mac registers after its word is
// accepted. Result k of a frame is caused by input word k+2W+2, so after the last
// pixel of a frame 2W+2 drain words flush the rest; drains sent while pixels are
// still expected are taken and dropped. The whole pipeline stalls while a finished
// result waits at the output. There is no clearing pass after reset.
module conv2d_5x5_border_padding (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cv2d_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cv2d_pkg::out_word_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                                           adv;
  logic                                           out_valid;
  cv2d_pkg::coef_rows_t                           coef;
  logic                                           we;
  logic [cv2d_pkg::COL_W-1:0]                     waddr;
  logic [cv2d_pkg::SLOT_W-1:0]                    wslot;
  logic [cv2d_pkg::PIX_W-1:0]                     wdata;
  logic [cv2d_pkg::COL_W-1:0]                     raddr;
  logic [cv2d_pkg::ROW_SLOTS*cv2d_pkg::PIX_W-1:0] rdata;
  cv2d_pkg::rd_ctrl_t                             s1;
  cv2d_pkg::win_ctrl_t                            s2;
  cv2d_pkg::window_t                              win;

  assign adv         = !out_valid || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid;

  cv2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_fire_i   (in_valid_i && adv),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .we_o        (we),
    .waddr_o     (waddr),
    .wslot_o     (wslot),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .s1_o        (s1)
  );

  cv2d_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wslot_i (wslot),
    .wdata_i (wdata),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cv2d_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s1_i    (s1),
    .rdata_i (rdata),
    .win_o   (win),
    .s2_o    (s2)
  );

  cv2d_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .coef_i      (coef),
    .win_i       (win),
    .s2_i        (s2),
    .out_valid_o (out_valid),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/conv2d_5x5_border_padding_tb.sv =====
// conv2d_5x5_border_padding_tb: self-checking testbench for the streaming 5x5 convolution
// with border padding. A scoreboard class predicts each output word and checks it.
// Depends on cv2d_pkg and the conv2d_5x5_border_padding RTL.
module conv2d_5x5_border_padding_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  class conv_scoreboard;
    logic [cv2d_pkg::CFG_DATA_W-1:0] coef_rows [cv2d_pkg::TAPS];
    cv2d_pkg::border_e               pad_mode;
    logic [10:0]                     cfg_width;
    logic [11:0]                     cfg_height;
    logic [cv2d_pkg::PIX_W-1:0]      rows_mem [cv2d_pkg::ROW_SLOTS*cv2d_pkg::MAX_WIDTH];
    int unsigned                     col, row, out_idx;
    cv2d_pkg::out_word_t             pending [$];
    int                              errors;
    int                              checked;

    function void clear();
      foreach (coef_rows[i]) coef_rows[i] = '0;
      coef_rows[2] = cv2d_pkg::CFG_DATA_W'(64'h8000_0000);
      pad_mode   = cv2d_pkg::BORDER_MIRROR;
      cfg_width  = 11'd256;
      cfg_height = 12'd256;
      foreach (rows_mem[i]) rows_mem[i] = '0;
      col = 0;
      row = 0;
      out_idx = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned eff_w();
      if (cfg_width < 3) return 3;
      if (cfg_width > cv2d_pkg::MAX_WIDTH) return cv2d_pkg::MAX_WIDTH;
      return cfg_width;
    endfunction

    function int unsigned eff_h();
      return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    function void write_reg(cv2d_pkg::cfg_idx_e idx, logic [cv2d_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cv2d_pkg::CFG_BORDER_MODE:
          pad_mode = (data[1:0] == 2'd3) ? cv2d_pkg::BORDER_MIRROR
                                         : cv2d_pkg::border_e'(data[1:0]);
        cv2d_pkg::CFG_IMAGE_WIDTH:  cfg_width = data[10:0];
        cv2d_pkg::CFG_IMAGE_HEIGHT: cfg_height = data[11:0];
        default:                    coef_rows[idx] = data;
      endcase
    endfunction

    function bit fold(int p, int n, output int q);
      if (p >= 0 && p < n) begin
        q = p;
        return 1'b1;
      end
      if (pad_mode == cv2d_pkg::BORDER_ZERO) return 1'b0;
      if (pad_mode == cv2d_pkg::BORDER_REPLICATE) q = (p < 0) ? 0 : n - 1;
      else q = (p < 0) ? -p - 1 : 2 * n - 1 - p;
      if (q < 0) q = 0;
      if (q > n - 1) q = n - 1;
      return 1'b1;
    endfunction

    function logic [cv2d_pkg::PIX_W-1:0] filter(int r, int c, int w, int h);
      longint acc;
      int y, x;
      logic signed [cv2d_pkg::COEF_W-1:0] k;
      acc = 0;
      for (int s = 0; s < cv2d_pkg::TAPS; s++) begin
        for (int t = 0; t < cv2d_pkg::TAPS; t++) begin
          if (!fold(r + s - 2, h, y)) continue;
          if (!fold(c + t - 2, w, x)) continue;
          k = coef_rows[s][t*cv2d_pkg::COEF_W +: cv2d_pkg::COEF_W];
          acc += longint'(rows_mem[(y % cv2d_pkg::ROW_SLOTS) * cv2d_pkg::MAX_WIDTH + x]) *
                 longint'(k);
        end
      end
      if (acc < 0) return '0;
      acc = acc >>> cv2d_pkg::COEF_FRAC_BITS;
      return (acc > cv2d_pkg::PIX_MAX) ? cv2d_pkg::PIX_W'(cv2d_pkg::PIX_MAX)
                                       : cv2d_pkg::PIX_W'(acc);
    endfunction

    function void note_input(cv2d_pkg::in_word_t wd);
      int unsigned w, h, total;
      bit emit;
      cv2d_pkg::out_word_t o;
      w = eff_w();
      h = eff_h();
      total = w * h;
      emit = 1'b0;
      if (row < h) begin
        if (wd.opcode == cv2d_pkg::OP_DRAIN) return;
        if (col >= w) col = w - 1;
        rows_mem[(row % cv2d_pkg::ROW_SLOTS) * cv2d_pkg::MAX_WIDTH + col] = wd.pixel_in;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
        if (row * w + col >= 2 * w + 3) emit = 1'b1;
      end else begin
        emit = 1'b1;
      end
      if (out_idx >= total) begin
        row = 0;
        col = 0;
        out_idx = 0;
        return;
      end
      if (!emit) return;
      o.pixel_out    = filter(out_idx / w, out_idx % w, w, h);
      o.end_of_row   = ((out_idx % w) == w - 1);
      o.end_of_frame = (out_idx == total - 1);
      pending = {pending, o};
      out_idx++;
      if (out_idx >= total) begin
        row = 0;
        col = 0;
        out_idx = 0;
      end
    endfunction

    function void check(cv2d_pkg::out_word_t got);
      cv2d_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got.pixel_out !== exp_w.pixel_out) begin
        $error("pixel_out expected %0d actual %0d", exp_w.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.end_of_row !== exp_w.end_of_row) begin
        $error("end_of_row expected %0b actual %0b", exp_w.end_of_row, got.end_of_row);
        errors++;
      end
      if (got.end_of_frame !== exp_w.end_of_frame) begin
        $error("end_of_frame expected %0b actual %0b", exp_w.end_of_frame, got.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  cv2d_pkg::in_word_t              in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  cv2d_pkg::out_word_t             out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [cv2d_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [cv2d_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  conv_scoreboard conv_sb = new();
  int  stall_cycles = 0;
  int  pixels_sent = 0;
  int  frames_sent = 0;
  bit  src_idle = 1'b1;
  bit  sink_idle = 1'b1;
  logic [10:0] width_reg;
  logic [11:0] height_reg;

  always #5 clk_i = ~clk_i;

  conv2d_5x5_border_padding DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        conv_sb.write_reg(cv2d_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && in_ready_o) conv_sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) conv_sb.check(out_data_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[conv2d_5x5_border_padding] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = sink_idle ? $urandom_range(0, 15) : 0;
      if (g > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_cfg(cv2d_pkg::cfg_idx_e idx, logic [cv2d_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == cv2d_pkg::CFG_IMAGE_WIDTH) width_reg = data[10:0];
    if (idx == cv2d_pkg::CFG_IMAGE_HEIGHT) height_reg = data[11:0];
  endtask

  task automatic push_word(logic op, logic [cv2d_pkg::PIX_W-1:0] pix);
    int g;
    g = src_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, pixel_in: pix};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [cv2d_pkg::CFG_DATA_W-1:0] rand_coef_row();
    logic [cv2d_pkg::CFG_DATA_W-1:0] v;
    int sv;
    for (int t = 0; t < cv2d_pkg::TAPS; t++) begin
      sv = $urandom_range(0, 80) - 40;
      v[t*cv2d_pkg::COEF_W +: cv2d_pkg::COEF_W] =
          ($urandom_range(0, 3) == 0) ? cv2d_pkg::COEF_W'($urandom_range(0, 4095))
                                      : cv2d_pkg::COEF_W'(sv);
    end
    return v;
  endfunction

  // full frame, with ignored drains sprinkled in and pixels mixed into the flush
  task automatic send_frame(bit directed);
    int unsigned w, h;
    w = (width_reg < 3) ? 3 :
        ((width_reg > cv2d_pkg::MAX_WIDTH) ? cv2d_pkg::MAX_WIDTH : width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) == 0) push_word(cv2d_pkg::OP_DRAIN, cv2d_pkg::PIX_W'($urandom));
      if (directed) push_word(cv2d_pkg::OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
      else push_word(cv2d_pkg::OP_PIXEL, cv2d_pkg::PIX_W'($urandom));
      pixels_sent++;
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      if ($urandom_range(0, 3) == 0) push_word(cv2d_pkg::OP_PIXEL, cv2d_pkg::PIX_W'($urandom));
      else push_word(cv2d_pkg::OP_DRAIN, cv2d_pkg::PIX_W'($urandom));
      pixels_sent++;
    end
    if ($urandom_range(0, 1) == 0) push_word(cv2d_pkg::OP_DRAIN, cv2d_pkg::PIX_W'($urandom));
    frames_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (conv_sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic random_phase(logic [10:0] w, logic [11:0] h);
    for (int s = 0; s < cv2d_pkg::TAPS; s++) begin
      write_cfg(cv2d_pkg::cfg_idx_e'(s), rand_coef_row());
    end
    write_cfg(cv2d_pkg::CFG_BORDER_MODE, cv2d_pkg::CFG_DATA_W'($urandom_range(0, 3)));
    write_cfg(cv2d_pkg::CFG_IMAGE_WIDTH, cv2d_pkg::CFG_DATA_W'(w));
    write_cfg(cv2d_pkg::CFG_IMAGE_HEIGHT, cv2d_pkg::CFG_DATA_W'(h));
    send_frame(1'b0);
    settle();
  endtask

  initial begin
    conv_sb.clear();
    width_reg = 11'd256;
    height_reg = 12'd256;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extreme coefficients, zero then replicate padding, undersized frame on 0/255 pixels
    write_cfg(cv2d_pkg::CFG_COEF_ROW0, {5{12'h7FF}});
    write_cfg(cv2d_pkg::CFG_COEF_ROW1, {5{12'h800}});
    write_cfg(cv2d_pkg::CFG_COEF_ROW2, {12'h000, 12'h001, 12'h080, 12'hFFF, 12'h7FF});
    write_cfg(cv2d_pkg::CFG_COEF_ROW3, '0);
    write_cfg(cv2d_pkg::CFG_COEF_ROW4, {12'h800, 12'h000, 12'h7FF, 12'h000, 12'h800});
    write_cfg(cv2d_pkg::CFG_BORDER_MODE, cv2d_pkg::CFG_DATA_W'(cv2d_pkg::BORDER_ZERO));
    write_cfg(cv2d_pkg::CFG_IMAGE_WIDTH, '0);
    write_cfg(cv2d_pkg::CFG_IMAGE_HEIGHT, '0);
    send_frame(1'b1);
    settle();
    write_cfg(cv2d_pkg::CFG_BORDER_MODE, cv2d_pkg::CFG_DATA_W'(cv2d_pkg::BORDER_REPLICATE));
    send_frame(1'b1);
    settle();

    while (pixels_sent < 820) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0)
        random_phase(11'($urandom_range(0, 2)), 12'($urandom_range(0, 2)));
      else
        random_phase(11'($urandom_range(3, 10)), 12'($urandom_range(3, 6)));
    end

    $display("covered %0d frames, %0d stream words, %0d output words checked",
             frames_sent, pixels_sent, conv_sb.checked);
    $display("border modes 0..3, widths 0..10, heights 0..6, random idling");
    if (conv_sb.errors == 0 && conv_sb.pending.size() == 0) begin
      $display("[conv2d_5x5_border_padding] OK");
    end else begin
      $display("[conv2d_5x5_border_padding] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/cv2d_pkg.sv
hdl/cv2d_line_mem.sv
hdl/cv2d_ctrl.sv
hdl/cv2d_window.sv
hdl/cv2d_mac.sv
hdl/conv2d_5x5_border_padding.sv
sim/conv2d_5x5_border_padding_tb.sv
